@@ rtl/lmsino_pkg.sv @@
// Package for the listmode offset to sinogram bin block.
// Holds widths, limits and the divider and segment search step functions.
// Has no dependencies.
package lmsino_pkg;

  // Field widths
  localparam int OffsetW = 30;
  localparam int DivW    = 10;
  localparam int ViewW   = 9;
  localparam int RingW   = 8;
  localparam int DiffW   = 7;
  localparam int SumW    = 16;

  // Scanner limits
  localparam int MAX_RINGS    = 128;
  localparam int MAX_SEGMENTS = 255;
  localparam int MaxDiff      = (MAX_SEGMENTS - 1) / 2;
  localparam int ViewLimit    = 512;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_TANG_BINS = 2'd0,
    REG_VIEWS     = 2'd1,
    REG_RINGS     = 2'd2,
    REG_MAX_DIFF  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [DivW-1:0]    rem;
    logic [OffsetW-1:0] num;
  } div_state_t;

  // One restoring division step: shift one dividend bit in, one quotient bit out
  function automatic div_state_t div_step(div_state_t s, logic [DivW-1:0] dvs);
    logic [DivW:0] t;
    logic [DivW:0] diff;
    logic          q;
    div_state_t    r;
    t    = {s.rem, s.num[OffsetW-1]};
    diff = t - {1'b0, dvs};
    q    = (t >= {1'b0, dvs});
    r.rem = q ? diff[DivW-1:0] : t[DivW-1:0];
    r.num = {s.num[OffsetW-2:0], q};
    return r;
  endfunction

  // Planes in all segment pairs 1..c: c * (2*rings - c - 1)
  function automatic logic [SumW-1:0] pair_sum(logic [DiffW-1:0] c, logic [RingW-1:0] rings);
    logic [RingW:0] m;
    m = {rings, 1'b0} - {2'b00, c} - (RingW+1)'(1);
    return SumW'(c) * SumW'(m);
  endfunction

endpackage

@@ rtl/listmode_offset_to_sinogram_bin.sv @@
// Top level of the listmode offset to sinogram bin block.
// Uses lmsino_pkg for widths, limits and the step functions.
//
// Usage:
//   Input channel (in_valid/in_ready, event_offset) takes one event offset a beat.
//   Output channel (out_valid/out_ready) returns one bin beat per event, in order.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   bin, view, ring and ring difference registers; cfg_ready is always high.
//   Write configuration only with the pipeline empty.
// Pipeline: an input register, 30 stages divide by the bin count, 30 stages
//   divide by the view count, 1 setup stage, 7 stages of binary search over the
//   segment pairs, 1 output stage.
// Throughput: one event per unstalled cycle; one quotient bit per divider stage.
// Reset: empties the pipeline and loads the register reset values.
// Stall: when the output beat waits, the whole pipeline holds and in_ready
//   drops; nothing is lost or repeated.
module listmode_offset_to_sinogram_bin (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lmsino_pkg::OffsetW-1:0]      event_offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [7:0]                   segment_number,
  output logic [lmsino_pkg::ViewW-1:0]        view_index,
  output logic [lmsino_pkg::DiffW-1:0]        axial_position,
  output logic signed [lmsino_pkg::DivW-1:0]  tangential_position,
  output logic                                out_of_range,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [lmsino_pkg::DivW-1:0]         cfg_data
);
  import lmsino_pkg::*;

  localparam int Steps = DiffW;

  // Configuration registers
  logic [DivW-1:0]  tangential_bins;
  logic [DivW-1:0]  view_count;
  logic [RingW-1:0] ring_count;
  logic [DiffW-1:0] max_ring_difference;

  // Effective values after clamping
  logic [DivW-1:0]  nt;
  logic [DivW-1:0]  nv;
  logic [RingW-1:0] rings;
  logic [DiffW-1:0] dmax;
  logic [RingW-1:0] dmax_w;

  // Divider stages
  logic             d1_v   [0:OffsetW];
  div_state_t       d1_s   [0:OffsetW];
  logic             d2_v   [1:OffsetW];
  div_state_t       d2_s   [1:OffsetW];
  logic [DivW-1:0]  d2_tang[1:OffsetW];

  // Segment search stages
  logic               sr_v   [0:Steps];
  logic [OffsetW-1:0] sr_z   [0:Steps];
  logic               sr_lt  [0:Steps];
  logic [DiffW-1:0]   sr_lo  [0:Steps];
  logic [SumW-1:0]    sr_s   [0:Steps];
  logic [ViewW-1:0]   sr_view[0:Steps];
  logic [DivW-1:0]    sr_tang[0:Steps];

  logic adv;

  // Search step and final decode, combinational
  logic [DiffW-1:0]   cand   [1:Steps];
  logic [SumW-1:0]    cand_s [1:Steps];
  logic               take   [1:Steps];
  logic [RingW-1:0]   fin_d;
  logic [RingW-1:0]   fin_size;
  logic [OffsetW-1:0] fin_r;
  logic [OffsetW-1:0] fin_r2;
  logic               fin_oor;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tangential_bins     <= DivW'(344);
      view_count          <= DivW'(252);
      ring_count          <= RingW'(64);
      max_ring_difference <= DiffW'(60);
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_TANG_BINS: tangential_bins     <= cfg_data;
        REG_VIEWS:     view_count          <= cfg_data;
        REG_RINGS:     ring_count          <= cfg_data[RingW-1:0];
        REG_MAX_DIFF:  max_ring_difference <= cfg_data[DiffW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp configuration
  always_comb begin
    nt = (tangential_bins == '0) ? DivW'(1) : tangential_bins;
    if (view_count == '0)                    nv = DivW'(1);
    else if (view_count > DivW'(ViewLimit))  nv = DivW'(ViewLimit);
    else                                     nv = view_count;
    rings  = (ring_count > RingW'(MAX_RINGS)) ? RingW'(MAX_RINGS) : ring_count;
    dmax_w = {1'b0, max_ring_difference};
    if (rings != '0 && dmax_w > rings - RingW'(1)) dmax_w = rings - RingW'(1);
    if (dmax_w > RingW'(MaxDiff)) dmax_w = RingW'(MaxDiff);
    dmax = dmax_w[DiffW-1:0];
  end

  // Search candidates: try the next lower bit of the pair count
  always_comb begin
    for (int k = 1; k <= Steps; k++) begin
      cand[k]   = sr_lo[k-1] | (DiffW'(1) << (Steps - k));
      cand_s[k] = pair_sum(cand[k], rings);
      take[k]   = (cand[k] <= dmax) && ({{(OffsetW-SumW){1'b0}}, cand_s[k]} <= sr_z[k-1]);
    end
  end

  // Final decode of the found segment pair
  always_comb begin
    fin_d    = {1'b0, sr_lo[Steps]} + RingW'(1);
    fin_size = rings - fin_d;
    fin_r    = sr_z[Steps] - {{(OffsetW-SumW){1'b0}}, sr_s[Steps]};
    fin_r2   = fin_r - {{(OffsetW-RingW){1'b0}}, fin_size};
    fin_oor  = (rings == '0) || (!sr_lt[Steps] && sr_lo[Steps] == dmax);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= OffsetW; k++) d1_v[k] <= 1'b0;
      for (int k = 1; k <= OffsetW; k++) d2_v[k] <= 1'b0;
      for (int k = 0; k <= Steps; k++)   sr_v[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      d1_v[0] <= in_valid;
      for (int k = 1; k <= OffsetW; k++) d1_v[k] <= d1_v[k-1];
      d2_v[1] <= d1_v[OffsetW];
      for (int k = 2; k <= OffsetW; k++) d2_v[k] <= d2_v[k-1];
      sr_v[0] <= d2_v[OffsetW];
      for (int k = 1; k <= Steps; k++)   sr_v[k] <= sr_v[k-1];
      out_valid <= sr_v[Steps];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_s[0].rem <= '0;
      d1_s[0].num <= event_offset;
      for (int k = 1; k <= OffsetW; k++) d1_s[k] <= div_step(d1_s[k-1], nt);

      d2_s[1]    <= div_step('{rem: '0, num: d1_s[OffsetW].num}, nv);
      d2_tang[1] <= d1_s[OffsetW].rem;
      for (int k = 2; k <= OffsetW; k++) begin
        d2_s[k]    <= div_step(d2_s[k-1], nv);
        d2_tang[k] <= d2_tang[k-1];
      end

      // Split off segment zero
      sr_lt[0]   <= d2_s[OffsetW].num < {{(OffsetW-RingW){1'b0}}, rings};
      sr_z[0]    <= (d2_s[OffsetW].num < {{(OffsetW-RingW){1'b0}}, rings}) ?
                    d2_s[OffsetW].num :
                    d2_s[OffsetW].num - {{(OffsetW-RingW){1'b0}}, rings};
      sr_lo[0]   <= '0;
      sr_s[0]    <= '0;
      sr_view[0] <= d2_s[OffsetW].rem[ViewW-1:0];
      sr_tang[0] <= d2_tang[OffsetW];

      for (int k = 1; k <= Steps; k++) begin
        sr_lt[k]   <= sr_lt[k-1];
        sr_z[k]    <= sr_z[k-1];
        sr_lo[k]   <= take[k] ? cand[k] : sr_lo[k-1];
        sr_s[k]    <= take[k] ? cand_s[k] : sr_s[k-1];
        sr_view[k] <= sr_view[k-1];
        sr_tang[k] <= sr_tang[k-1];
      end

      // Output register
      view_index          <= sr_view[Steps];
      tangential_position <= sr_tang[Steps] - (nt >> 1);
      out_of_range        <= fin_oor;
      if (fin_oor) begin
        segment_number <= '0;
        axial_position <= '0;
      end else if (sr_lt[Steps]) begin
        segment_number <= '0;
        axial_position <= sr_z[Steps][DiffW-1:0];
      end else if (fin_r < {{(OffsetW-RingW){1'b0}}, fin_size}) begin
        segment_number <= 8'd0 - fin_d;
        axial_position <= fin_r[DiffW-1:0];
      end else begin
        segment_number <= fin_d;
        axial_position <= fin_r2[DiffW-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (segment_number == 8'sd0 && axial_position == '0))
    else $error("out of range beat carries a segment or plane");
  a_view_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, view_index} < nv))
    else $error("view index not below view count");
`endif

endmodule
